>>> rtl/cholesky_lower_decompose_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lower Cholesky factor block
// Shared property wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CHOLESKY_LOWER_DECOMPOSE_ASSERT_SVH
`define CHOLESKY_LOWER_DECOMPOSE_ASSERT_SVH

// Same-cycle implication.
`define CHOL_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle implication failed.");

// Next-cycle implication.
`define CHOL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle implication failed.");

`endif

>>> rtl/chol_pkg.sv
// ----------------------------------------------------------------------------
// Package for the lower Cholesky factor block
// Widths, limits and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package chol_pkg;

    localparam int MAX_DIM    = 8;
    localparam int DIM_W      = 3;
    localparam int ADDR_W     = 2 * DIM_W;
    localparam int SIZE_W     = 4;
    localparam int DATA_W     = 32;
    localparam int SUM_W      = 52;
    localparam int PROD_W     = 65;
    localparam int ROOT_W     = 25;
    localparam int RAD_W      = 47;
    localparam int STEP_W     = 6;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_BITS   = 32;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RD_A,
        S_GET_A,
        S_GET_X,
        S_GET_Y,
        S_ACC,
        S_FIN,
        S_SCALE,
        S_SQRT,
        S_DIV,
        S_ERR,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WT
    } chol_state_t;

endpackage

`default_nettype wire

>>> rtl/cholesky_lower_decompose.sv
// Sequence: all n*n elements load first; each entry then runs GET_X, GET_Y and ACC per term,
// with a bisection root per diagonal and a bit-serial reciprocal per column.
// Output: each result is read, loaded and held until ready; one memory port sets the pace.
// Throughput: one matrix at a time; no new transaction is taken until the last result.
// Reset: size returns to 8 and loading restarts; the matrix memory is not cleared.
// ----------------------------------------------------------------------------
// Lower Cholesky factor
// Loads an n-by-n Q16.16 matrix and streams its lower Cholesky factor or a not-definite result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cholesky_lower_decompose_assert.svh"

module cholesky_lower_decompose (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata,      // matrix_size
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // element_value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // factor_value, row_index, col_index, zero fill
    output logic             m_axis_tuser,   // not_definite
    output logic             m_axis_tlast    // last_result
);

    localparam int DW = chol_pkg::DIM_W;
    localparam int AW = chol_pkg::ADDR_W;

    logic [chol_pkg::DATA_W-1:0] mem [0:(1 << AW)-1];
    logic [chol_pkg::DATA_W-1:0] rdata_reg;

    chol_pkg::chol_state_t state_reg, state_next;
    logic [chol_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [DW-1:0] lrow_reg, lrow_next, lcol_reg, lcol_next;
    logic [DW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic signed [chol_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [chol_pkg::DATA_W-1:0] x_reg, x_next;
    logic signed [chol_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [chol_pkg::ROOT_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [chol_pkg::RAD_W-1:0] rad_reg, rad_next;
    logic [chol_pkg::STEP_W-1:0] step_reg, step_next;
    logic [chol_pkg::ROOT_W-1:0] rem_reg, rem_next;
    logic [chol_pkg::DATA_W-1:0] quo_reg, quo_next;
    logic [chol_pkg::DATA_W-1:0] recip_reg, recip_next;
    logic out_valid_reg, out_valid_next;
    logic [chol_pkg::DATA_W-1:0] out_val_reg, out_val_next;
    logic [DW-1:0] out_row_reg, out_row_next, out_col_reg, out_col_next;
    logic out_err_reg, out_err_next, out_last_reg, out_last_next;

    logic [DW-1:0] nm1;
    logic [AW-1:0] raddr, waddr;
    logic we;
    logic [chol_pkg::DATA_W-1:0] wdata;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [chol_pkg::DATA_W-1:0] sum_sat, scale_sat;
    logic signed [48:0] scaled;
    logic [chol_pkg::ROOT_W:0] mid_sum;
    logic [chol_pkg::ROOT_W-1:0] mid;
    logic [2*chol_pkg::ROOT_W-1:0] mid_sq;
    logic [chol_pkg::ROOT_W:0] rem_sh;
    logic in_acc;

    always_comb
    begin
        if (size_reg == '0)
        begin
            nm1 = '0;
        end
        else if (size_reg > chol_pkg::SIZE_W'(chol_pkg::MAX_DIM))
        begin
            nm1 = DW'(chol_pkg::MAX_DIM - 1);
        end
        else
        begin
            nm1 = DW'(size_reg - 1'b1);
        end
    end

    assign mul_p  = mul_a * mul_b;
    assign scaled = prod_reg[64:16];

    always_comb
    begin
        if (sum_reg > chol_pkg::SUM_W'(signed'(32'sh7fffffff)))
        begin
            sum_sat = 32'sh7fffffff;
        end
        else if (sum_reg < chol_pkg::SUM_W'(signed'(-33'sh80000000)))
        begin
            sum_sat = 32'sh80000000;
        end
        else
        begin
            sum_sat = sum_reg[31:0];
        end
        if (scaled > 49'sh7fffffff)
        begin
            scale_sat = 32'sh7fffffff;
        end
        else if (scaled < -49'sh80000000)
        begin
            scale_sat = 32'sh80000000;
        end
        else
        begin
            scale_sat = scaled[31:0];
        end
    end

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[chol_pkg::ROOT_W:1];
    assign mid_sq  = mid * mid;
    assign rem_sh  = {rem_reg, (step_reg == chol_pkg::STEP_W'(chol_pkg::DIV_BITS))};

    assign in_acc = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        lrow_next      = lrow_reg;
        lcol_next      = lcol_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        sum_next       = sum_reg;
        x_next         = x_reg;
        prod_next      = prod_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        rad_next       = rad_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        recip_next     = recip_reg;
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;
        raddr          = {i_reg, j_reg};
        waddr          = {lrow_reg, lcol_reg};
        we             = 1'b0;
        wdata          = s_axis_tdata;
        mul_a          = {x_reg[31], x_reg};
        mul_b          = {rdata_reg[31], rdata_reg};
        s_axis_tready  = 1'b0;

        unique case (state_reg)
            chol_pkg::S_LOAD:
            begin
                s_axis_tready = 1'b1;
                if (in_acc)
                begin
                    we = 1'b1;
                    if (lcol_reg == nm1)
                    begin
                        lcol_next = '0;
                        if (lrow_reg == nm1)
                        begin
                            lrow_next  = '0;
                            i_next     = '0;
                            j_next     = '0;
                            state_next = chol_pkg::S_RD_A;
                        end
                        else
                        begin
                            lrow_next = lrow_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        lcol_next = lcol_reg + 1'b1;
                    end
                end
            end
            chol_pkg::S_RD_A:
            begin
                raddr      = {i_reg, j_reg};
                state_next = chol_pkg::S_GET_A;
            end
            chol_pkg::S_GET_A:
            begin
                sum_next = chol_pkg::SUM_W'(signed'(rdata_reg));
                k_next   = '0;
                if (i_reg == '0)
                begin
                    state_next = chol_pkg::S_FIN;
                end
                else
                begin
                    raddr      = {i_reg, DW'(0)};
                    state_next = chol_pkg::S_GET_X;
                end
            end
            chol_pkg::S_GET_X:
            begin
                x_next     = rdata_reg;
                raddr      = {j_reg, k_reg};
                state_next = chol_pkg::S_GET_Y;
            end
            chol_pkg::S_GET_Y:
            begin
                prod_next  = mul_p[64:0];
                state_next = chol_pkg::S_ACC;
            end
            chol_pkg::S_ACC:
            begin
                sum_next = sum_reg - chol_pkg::SUM_W'(scaled);
                if (k_reg == i_reg - 1'b1)
                begin
                    state_next = chol_pkg::S_FIN;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    raddr      = {i_reg, k_reg + 1'b1};
                    state_next = chol_pkg::S_GET_X;
                end
            end
            chol_pkg::S_FIN:
            begin
                mul_a = {sum_sat[31], sum_sat};
                mul_b = {1'b0, recip_reg};
                if (i_reg == j_reg)
                begin
                    if (sum_sat <= 0)
                    begin
                        state_next = chol_pkg::S_ERR;
                    end
                    else
                    begin
                        rad_next   = {sum_sat[30:0], 16'h0000};
                        lo_next    = '0;
                        hi_next    = chol_pkg::ROOT_W'(1) << 24;
                        step_next  = '0;
                        state_next = chol_pkg::S_SQRT;
                    end
                end
                else
                begin
                    prod_next  = mul_p[64:0];
                    state_next = chol_pkg::S_SCALE;
                end
            end
            chol_pkg::S_SCALE:
            begin
                we    = 1'b1;
                waddr = {j_reg, i_reg};
                wdata = scale_sat;
                if (j_reg == nm1)
                begin
                    if (i_reg == nm1)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = chol_pkg::S_OUT_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        j_next     = i_reg + 1'b1;
                        state_next = chol_pkg::S_RD_A;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = chol_pkg::S_RD_A;
                end
            end
            chol_pkg::S_SQRT:
            begin
                if ((step_reg == chol_pkg::STEP_W'(chol_pkg::SQRT_STEPS))
                    || (hi_reg - lo_reg <= chol_pkg::ROOT_W'(1)))
                begin
                    we         = 1'b1;
                    waddr      = {i_reg, i_reg};
                    wdata      = chol_pkg::DATA_W'(lo_reg);
                    rem_next   = '0;
                    quo_next   = '0;
                    step_next  = chol_pkg::STEP_W'(chol_pkg::DIV_BITS);
                    state_next = chol_pkg::S_DIV;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                    if (mid_sq <= (2*chol_pkg::ROOT_W)'(rad_reg))
                    begin
                        lo_next = mid;
                    end
                    else
                    begin
                        hi_next = mid;
                    end
                end
            end
            chol_pkg::S_DIV:
            begin
                if (rem_sh >= {1'b0, lo_reg})
                begin
                    rem_next = chol_pkg::ROOT_W'(rem_sh - {1'b0, lo_reg});
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[chol_pkg::ROOT_W-1:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    recip_next = quo_next;
                    if (j_reg == nm1)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = chol_pkg::S_OUT_RD;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = chol_pkg::S_RD_A;
                    end
                end
            end
            chol_pkg::S_ERR:
            begin
                out_valid_next = 1'b1;
                out_val_next   = '0;
                out_row_next   = i_reg;
                out_col_next   = i_reg;
                out_err_next   = 1'b1;
                out_last_next  = 1'b1;
                state_next     = chol_pkg::S_OUT_WT;
            end
            chol_pkg::S_OUT_RD:
            begin
                raddr      = {i_reg, j_reg};
                state_next = chol_pkg::S_OUT_LD;
            end
            chol_pkg::S_OUT_LD:
            begin
                out_valid_next = 1'b1;
                out_val_next   = (j_reg <= i_reg) ? rdata_reg : '0;
                out_row_next   = i_reg;
                out_col_next   = j_reg;
                out_err_next   = 1'b0;
                out_last_next  = (i_reg == nm1) && (j_reg == nm1);
                state_next     = chol_pkg::S_OUT_WT;
            end
            chol_pkg::S_OUT_WT:
            begin
                if (m_axis_tready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = chol_pkg::S_LOAD;
                    end
                    else
                    begin
                        if (j_reg == nm1)
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                        state_next = chol_pkg::S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = chol_pkg::S_LOAD;
            end
        endcase

        if (cfg_we)
        begin
            size_next = cfg_wdata;
            lrow_next = '0;
            lcol_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chol_pkg::S_LOAD;
            size_reg      <= chol_pkg::SIZE_W'(chol_pkg::MAX_DIM);
            lrow_reg      <= '0;
            lcol_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            step_reg      <= '0;
            recip_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            lrow_reg      <= lrow_next;
            lcol_reg      <= lcol_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            step_reg      <= step_next;
            recip_reg     <= recip_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        x_reg        <= x_next;
        prod_reg     <= prod_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        out_val_reg  <= out_val_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_err_reg  <= out_err_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_col_reg, out_row_reg, out_val_reg};
    assign m_axis_tuser  = out_err_reg;
    assign m_axis_tlast  = out_last_reg;

    `CHOL_ASSERT_IMPLY(a_ready_excl, s_axis_tready, !m_axis_tvalid)
    `CHOL_ASSERT_IMPLY(a_err_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
    `CHOL_ASSERT_NEXT(a_cfg_restart, cfg_we, (lrow_reg == '0) && (lcol_reg == '0))

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the lower Cholesky factor block
// Streams square matrices of several sizes, predicts the lower factor or
// the not-definite result, and compares every output transaction.
// ----------------------------------------------------------------------------

module tb;

    typedef struct packed {
        logic [31:0] factor;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        not_def;
        logic        last;
    } factor_t;

    localparam int SETTLE = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_wdata = 4'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 32'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    logic [31:0] element_q[$];
    factor_t     factor_q[$];

    logic [31:0] matrix_mem[64];
    int          loaded;
    logic [31:0] recip;
    logic [3:0]  size_reg;

    logic        in_fire = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_pct = 0;
    int          stall_age = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          errors_seen = 0;
    int          matrices = 0;
    int          items_sent = 0;

    cholesky_lower_decompose dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic int dim_of(logic [3:0] raw);
        if (raw == 4'd0)
            return 1;
        if (raw > chol_pkg::MAX_DIM)
            return chol_pkg::MAX_DIM;
        return int'(raw);
    endfunction

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] x);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 64'd0;
        hi = 64'd1 << 24;
        for (int k = 0; k < chol_pkg::SQRT_STEPS; k++)
        begin
            if (hi - lo <= 64'd1)
                break;
            mid = (lo + hi) >> 1;
            if (mid * mid <= x)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // Runs the factorization on the stored matrix and queues its results.
    task automatic factorize(int n);
        longint      sum;
        longint      prod;
        logic [63:0] root;
        factor_t     f;
        for (int i = 0; i < n; i++)
        begin
            for (int j = i; j < n; j++)
            begin
                sum = longint'($signed(matrix_mem[i * n + j]));
                for (int k = 0; k < i; k++)
                begin
                    prod = longint'($signed(matrix_mem[i * n + k]))
                         * longint'($signed(matrix_mem[j * n + k]));
                    sum -= prod >>> 16;
                end
                sum = sat_word(sum);
                if (i == j)
                begin
                    if (sum <= 0)
                    begin
                        f = '{32'd0, 3'(i), 3'(i), 1'b1, 1'b1};
                        factor_q.push_back(f);
                        return;
                    end
                    root = floor_root(64'(sum) << 16);
                    matrix_mem[i * n + i] = root[31:0];
                    recip = 32'((64'd1 << 32) / root);
                end
                else
                begin
                    matrix_mem[j * n + i] =
                        32'(sat_word((sum * longint'({32'd0, recip})) >>> 16));
                end
            end
        end
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
            begin
                f.factor  = (c <= r) ? matrix_mem[r * n + c] : 32'd0;
                f.row     = 3'(r);
                f.col     = 3'(c);
                f.not_def = 1'b0;
                f.last    = (r == n - 1) && (c == n - 1);
                factor_q.push_back(f);
            end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
            loaded  = 0;
        end
        else
        begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (loaded < 64)
                    matrix_mem[loaded] = s_axis_tdata;
                loaded = loaded + 1;
                if (loaded >= dim_of(size_reg) * dim_of(size_reg))
                begin
                    loaded = 0;
                    factorize(dim_of(size_reg));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (element_q.size() > 0)
            begin
                s_axis_tdata  <= element_q.pop_front();
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left = burst_left - 1;
                else
                begin
                    burst_left = $urandom_range(0, 20);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (stall_age == 0)
        begin
            stall_age = $urandom_range(50, 300);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end
        stall_age = stall_age - 1;
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        factor_t got;
        factor_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tdata[37:35],
                    m_axis_tuser, m_axis_tlast};
            results_seen++;
            if (got.not_def)
                errors_seen++;
            if (factor_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected transaction: %p", got);
            end
            else
            begin
                want = factor_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    task automatic wait_idle();
        do
            @(posedge clk);
        while (element_q.size() > 0 || s_axis_tvalid || factor_q.size() > 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_size(logic [3:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        size_reg  = value;
        loaded    = 0;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Shape: 0 well-formed, 1 random noise, 2 a diagonal made non-positive.
    task automatic push_matrix(int n, int shape);
        logic [31:0] a[64];
        int          bad;
        bad = $urandom_range(0, n - 1);
        for (int r = 0; r < n; r++)
            for (int c = r; c < n; c++)
            begin
                if (shape == 1)
                    a[r * n + c] = $urandom;
                else if (r == c)
                    a[r * n + c] = 32'(n << 18) + $urandom_range(0, 1 << 22);
                else
                    a[r * n + c] = 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
            end
        if (shape == 2)
            a[bad * n + bad] = ($urandom_range(0, 1) == 0) ? 32'd0 : -$urandom_range(1, 1 << 20);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                element_q.push_back((c < r) ? $urandom : a[r * n + c]);
        items_sent += n * n;
        matrices++;
    endtask

    initial
    begin
        int n;
        int pick;
        size_reg = 4'd8;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_size(4'd1);
        element_q.push_back(32'h7FFF_FFFF);
        element_q.push_back(32'h8000_0000);
        element_q.push_back(32'h0000_0000);
        element_q.push_back(32'h0000_0001);
        write_size(4'd0);
        element_q.push_back(32'h0001_0000);
        write_size(4'd2);
        element_q.push_back(32'h0004_0000);
        element_q.push_back(32'h0002_0000);
        element_q.push_back(32'hDEAD_BEEF);
        element_q.push_back(32'h0001_0000);
        write_size(4'd3);
        element_q.push_back(32'h0001_0000);
        element_q.push_back(32'h0002_0000);
        element_q.push_back(32'h7FFF_FFFF);
        wait_idle();
        write_size(4'd3);
        push_matrix(3, 2);
        write_size(4'd15);
        push_matrix(8, 0);

        while (items_sent < 320)
        begin
            pick = $urandom_range(0, 9);
            n = (pick < 6) ? $urandom_range(1, 4) : (pick < 9) ? $urandom_range(5, 7) : 8;
            write_size(4'(n));
            repeat ($urandom_range(1, 4))
            begin
                pick = $urandom_range(0, 19);
                push_matrix(n, (pick < 14) ? 0 : (pick < 17) ? 1 : 2);
            end
        end
        write_size(4'd8);
        wait_idle();

        $display("Ran %0d matrices (%0d elements), checked %0d results, %0d not definite.",
                 matrices, items_sent, results_seen, errors_seen);
        $display("Mismatches: %0d.", mismatches);
        if (mismatches == 0 && factor_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout with %0d results outstanding.", factor_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/chol_pkg.sv
rtl/cholesky_lower_decompose.sv
dv/tb.sv
